>>> src/insertion_sorter_top_defines.svh
// Assertion macros for the insertion sorter.
`ifndef INSERTION_SORTER_TOP_DEFINES_SVH
`define INSERTION_SORTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define ISORT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("insertion sorter check failed");
// Next-cycle implication.
`define ISORT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("insertion sorter check failed");
`else
`define ISORT_ASSERT_NOW(label, ante, cons)
`define ISORT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/isort_pkg.sv
package isort_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_flag;
        logic [1:0]                status;
    } isort_result_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic insert;   // insert the broadcast value this cycle
        logic fetch;    // shift the row one place towards cell 0
        logic restart;  // treat the row as empty (load after a closed set)
    } isort_ctrl_t;

endpackage

>>> src/isort_cell.sv
module isort_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  isort_pkg::isort_ctrl_t              ctrl,
    input  logic signed [isort_pkg::VALUE_W-1:0] new_value,
    input  logic signed [isort_pkg::VALUE_W-1:0] left_value,
    input  logic                                left_occ,
    input  logic                                left_gt,
    input  logic signed [isort_pkg::VALUE_W-1:0] right_value,
    input  logic                                right_occ,
    output logic signed [isort_pkg::VALUE_W-1:0] value,
    output logic                                occ,
    output logic                                occ_held,
    output logic                                gt
);

    logic signed [isort_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                                 occ_reg, occ_next;

    // Occupancy as seen this cycle: a restart empties the whole row.
    assign occ      = occ_reg && !ctrl.restart;
    assign occ_held = occ_reg;
    assign value    = value_reg;
    // Strictly greater keeps equal values in arrival order.
    assign gt       = occ && (value_reg > new_value);

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.insert) begin
            if (left_gt) begin
                value_next = left_value;
                occ_next   = 1'b1;
            end else if (gt || (!occ && left_occ)) begin
                value_next = new_value;
                occ_next   = 1'b1;
            end else begin
                occ_next   = occ;
            end
        end else if (ctrl.fetch) begin
            value_next = right_value;
            occ_next   = right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
        value_reg <= value_next;
    end

endmodule

>>> src/isort_obuf.sv
module isort_obuf (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  isort_pkg::isort_result_t push_data,
    output logic                     room,
    output logic                     out_valid,
    input  logic                     out_ready,
    output isort_pkg::isort_result_t out_data
);

    isort_pkg::isort_result_t head_reg, head_next;
    isort_pkg::isort_result_t tail_reg, tail_next;
    logic [1:0]               count_reg, count_next;
    logic                     pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (push && pop) begin
            // Push is only offered with room, so the queue holds one item here.
            head_next = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

>>> src/insertion_sorter_top.sv
// Channel  | Direction | Ports                                          | Handshake
// input    | in        | s_opcode, s_value, s_load_last                 | s_valid / s_ready
// result   | out       | m_sorted_value, m_final_flag, m_status         | m_valid / m_ready
//
// One item is taken every cycle while the two-entry result queue has room.
// A load accepted while the row is not full inserts its value into the cell row in that cycle;
// a fetch of a closed, non-empty set shifts the row one place towards cell 0 in the same cycle.
// Results pass through the registered result queue before they appear on the result channel.
// Reset (aresetn low, synchronous) empties the row and the result queue.
// s_ready drops only while two results wait in the result queue.

`include "insertion_sorter_top_defines.svh"

module insertion_sorter_top #(
    parameter int CAPACITY = isort_pkg::CAPACITY
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_opcode,
    input  logic signed [isort_pkg::VALUE_W-1:0] s_value,
    input  logic                                 s_load_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [isort_pkg::VALUE_W-1:0] m_sorted_value,
    output logic                                 m_final_flag,
    output logic [1:0]                           m_status
);

    // Row of cells, cell 0 holding the smallest value.
    logic signed [isort_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]                  occ_eff;
    logic [CAPACITY-1:0]                  occ_held;
    logic [CAPACITY-1:0]                  cell_gt;

    isort_pkg::isort_ctrl_t   ctrl;
    isort_pkg::isort_result_t result;
    isort_pkg::isort_result_t out_data;

    logic closed_reg, closed_next;
    logic accept;
    logic is_load;
    logic full;
    logic fetch_ok;
    logic push;

    assign accept  = s_valid && s_ready;
    assign is_load = (s_opcode == isort_pkg::OP_LOAD);

    // A load after a closed set starts from an empty row.
    assign ctrl.restart = closed_reg && is_load;
    // Full is judged after that restart: the last cell holds a value.
    assign full         = occ_eff[CAPACITY-1];
    // A set can be read out only once it is closed.
    assign fetch_ok     = closed_reg && occ_eff[0];
    assign ctrl.insert  = accept && is_load && !full;
    assign ctrl.fetch   = accept && !is_load && fetch_ok;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [isort_pkg::VALUE_W-1:0] lv, rv;
        logic                                 lo, lg, ro;
        if (i == 0) begin : g_first
            assign lv = '0;
            assign lo = 1'b1;
            assign lg = 1'b0;
        end else begin : g_mid
            assign lv = cell_value[i-1];
            assign lo = occ_eff[i-1];
            assign lg = cell_gt[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign rv = '0;
            assign ro = 1'b0;
        end else begin : g_inner
            assign rv = cell_value[i+1];
            assign ro = occ_eff[i+1];
        end
        isort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_value   (s_value),
            .left_value  (lv),
            .left_occ    (lo),
            .left_gt     (lg),
            .right_value (rv),
            .right_occ   (ro),
            .value       (cell_value[i]),
            .occ         (occ_eff[i]),
            .occ_held    (occ_held[i]),
            .gt          (cell_gt[i])
        );
    end

    // Build the result: loads answer only when dropped, every fetch answers.
    always_comb begin
        result.sorted_value = '0;
        result.final_flag   = 1'b0;
        result.status       = isort_pkg::ST_EMPTY;
        push                = 1'b0;
        if (accept) begin
            if (is_load) begin
                push          = full;
                result.status = isort_pkg::ST_FULL;
            end else begin
                push = 1'b1;
                if (fetch_ok) begin
                    result.sorted_value = cell_value[0];
                    result.final_flag   = !occ_eff[1];
                    result.status       = isort_pkg::ST_OK;
                end
            end
        end
    end

    // Every load, dropped or not, leaves the set closed exactly when marked last.
    always_comb begin
        closed_next = closed_reg;
        if (accept && is_load) begin
            closed_next = s_load_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg <= 1'b0;
        end else begin
            closed_reg <= closed_next;
        end
    end

    // Hold results here so the row keeps taking items under a stalled sink.
    isort_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_sorted_value = out_data.sorted_value;
    assign m_final_flag   = out_data.final_flag;
    assign m_status       = out_data.status;

    `ISORT_ASSERT_NEXT(a_insert_fills_head, ctrl.insert, occ_held[0])
    `ISORT_ASSERT_NEXT(a_final_empties_row, ctrl.fetch && !occ_eff[1], !occ_held[0])
    `ISORT_ASSERT_NOW(a_row_packed, 1'b1, ((occ_held & (occ_held + 1'b1)) == '0))
    `ISORT_ASSERT_NOW(a_stall_has_result, !s_ready, m_valid)

endmodule

>>> dv/insertion_sorter_top_test.sv
module insertion_sorter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import isort_pkg::*;

    // Cycles without any handshake on either channel before the run is abandoned.
    // The longest legitimate quiet spell is a long sender gap plus a long receiver
    // stall, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 1800;
    localparam int TAIL_CYCLES    = 10;

    typedef struct {
        logic                      opcode;
        logic signed [VALUE_W-1:0] value;
        logic                      load_last;
        bit                        hold;     // wait for every due result before driving
    } sort_item_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_opcode = OP_LOAD;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      s_load_last = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_sorted_value;
    logic                      m_final_flag;
    logic [1:0]                m_status;

    insertion_sorter_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .s_load_last    (s_load_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_final_flag   (m_final_flag),
        .m_status       (m_status)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the sorted row and its bookkeeping.
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] row [CAPACITY];
    int                        row_count = 0;
    int                        row_rd    = 0;
    bit                        row_closed = 1'b0;

    isort_result_t due_results [$];   // results owed by the block, oldest first
    sort_item_t    stim_items [$];    // items waiting to be driven
    int            total_items = 0;
    int            items_sent  = 0;
    int            mismatches  = 0;
    int            idle_cycles = 0;

    // Apply one accepted item to the predicted row and queue any result it owes.
    task automatic advance_sorted_row(input sort_item_t it);
        isort_result_t res;
        int            i;
        res = '0;
        if (it.opcode == OP_LOAD) begin
            // A load after a closed set starts afresh.
            if (row_closed) begin
                row_count  = 0;
                row_rd     = 0;
                row_closed = 1'b0;
            end
            if (row_count < CAPACITY) begin
                // Shift strictly greater entries up; equal ones stay ahead (stable).
                i = row_count;
                while (i > 0 && row[i-1] > it.value) begin
                    row[i] = row[i-1];
                    i--;
                end
                row[i] = it.value;
                row_count++;
            end else begin
                res.status = ST_FULL;
                due_results.push_back(res);
            end
            // The last mark closes the set even when the value was dropped.
            if (it.load_last) row_closed = 1'b1;
        end else begin
            if (row_closed && row_rd < row_count) begin
                res.sorted_value = row[row_rd];
                res.final_flag   = (row_rd + 1 == row_count);
                res.status       = ST_OK;
                row_rd++;
            end else begin
                res.status = ST_EMPTY;
            end
            due_results.push_back(res);
        end
    endtask

    // Mostly short gaps, a few long ones; none at all during a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return $urandom_range(0, 8) - 4;   // crowd of duplicates near zero
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(input logic op, input logic signed [VALUE_W-1:0] val,
                            input logic last, input bit hold = 1'b0);
        sort_item_t it;
        it.opcode    = op;
        it.value     = val;
        it.load_last = last;
        it.hold      = hold;
        stim_items.push_back(it);
        total_items++;
    endtask

    // One well-formed set: n loads, last mark on the final one, then some fetches.
    task automatic add_set(input int n, input int fetches, input bit hold);
        for (int k = 0; k < n; k++)
            add_item(OP_LOAD, pick_value(), k == n - 1, hold && k == 0);
        for (int k = 0; k < fetches; k++)
            add_item(OP_FETCH, pick_value(), $urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------
    // Driver: present items from the queue, honour gaps and drain holds.
    // ------------------------------------------------------------------
    sort_item_t cur_item;
    int         send_gap  = 0;
    bit         send_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_sorted_row(cur_item);
                items_sent++;
            end
            // Hold the current item until it is taken; otherwise pick the next.
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (stim_items.size() > 0 &&
                             !(stim_items[0].hold && due_results.size() != 0)) begin
                    cur_item = stim_items.pop_front();
                    s_valid     <= 1'b1;
                    s_opcode    <= cur_item.opcode;
                    s_value     <= cur_item.value;
                    s_load_last <= cur_item.load_last;
                    if ($urandom_range(0, 149) == 0) send_calm = ~send_calm;
                    send_gap = pick_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare every accepted result.
    // ------------------------------------------------------------------
    int recv_stall = 0;
    bit recv_calm  = 1'b0;

    task automatic note_mismatch(input string what, input isort_result_t want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected value %0d final %0b status %0d, got value %0d final %0b status %0d",
                     $realtime, what, want.sorted_value, want.final_flag, want.status,
                     m_sorted_value, m_final_flag, m_status);
    endtask

    always @(posedge aclk) begin
        isort_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    note_mismatch("no result due", '0);
                end else begin
                    want = due_results.pop_front();
                    if (m_sorted_value !== want.sorted_value ||
                        m_final_flag !== want.final_flag ||
                        m_status !== want.status)
                        note_mismatch("field", want);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) recv_calm = ~recv_calm;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int n;
        int n_kept;
        int r;

        // Directed: fetch from nothing, extremes, open-set fetch, duplicates.
        add_item(OP_FETCH, 32'sh0, 1'b1);
        add_item(OP_LOAD, 32'sh7FFF_FFFF, 1'b0);
        add_item(OP_LOAD, 32'sh8000_0000, 1'b0);
        add_item(OP_FETCH, 32'sh0, 1'b0);
        add_item(OP_LOAD, 32'sh0, 1'b0);
        add_item(OP_LOAD, -32'sd1, 1'b0);
        add_item(OP_LOAD, 32'sd5, 1'b0);
        add_item(OP_LOAD, 32'sd5, 1'b0);
        add_item(OP_LOAD, -32'sd1, 1'b1);
        for (int k = 0; k < 7; k++) add_item(OP_FETCH, $urandom, k[0]);
        // Read past the end of a closed set.
        add_item(OP_FETCH, 32'sh0, 1'b0);
        // New set after a fully read one, then restart a partly read one.
        add_item(OP_LOAD, 32'sd3, 1'b0);
        add_item(OP_LOAD, 32'sd1, 1'b1);
        add_item(OP_FETCH, 32'sh0, 1'b0);
        add_item(OP_LOAD, 32'sd9, 1'b1);
        add_item(OP_FETCH, 32'sh0, 1'b0);
        add_item(OP_FETCH, 32'sh0, 1'b0);

        // Overflow the store, last mark on a dropped load, after a full drain.
        add_set(CAPACITY + 2, CAPACITY + 1, 1'b1);

        // Random: mostly well-formed sets, small sizes, some noise and breakage.
        while (total_items < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 80)      n = $urandom_range(1, 8);
            else if (r < 95) n = $urandom_range(9, 40);
            else if (r < 99) n = $urandom_range(CAPACITY - 4, CAPACITY);
            else             n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            n_kept = (n > CAPACITY) ? CAPACITY : n;
            r = $urandom_range(0, 99);
            if (r < 75) begin
                add_set(n, n_kept + $urandom_range(0, 2), $urandom_range(0, 49) == 0);
            end else if (r < 90) begin
                // Partial read-out; the next load throws the rest away.
                add_set(n, $urandom_range(0, n_kept - 1), 1'b0);
            end else begin
                // Noise: anything at all, including loads into an open set.
                repeat ($urandom_range(1, 4))
                    add_item($urandom_range(0, 1), pick_value(), $urandom_range(0, 1));
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_sent < total_items) @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (due_results.size() != 0) begin
            $display("%0d results still due at the end", due_results.size());
            mismatches += due_results.size();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
